### rtl/ofd_pkg.sv
`default_nettype none

package ofd_pkg;

    localparam int CFG_W     = 11;
    localparam int CELL_W    = 8;
    localparam int COL_OUT_W = 10;
    localparam int ROW_OUT_W = 10;

    localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;
    localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;

    // per-cell context handed from the raster tracker to the decision stage
    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 last;
        logic                 below_free;
        logic                 own_par;
        logic                 left_ok;
        logic                 right_ok;
        logic                 above_ok;
    } ofd_ctx_t;

endpackage

`default_nettype wire

### rtl/ofd_ram.sv
`default_nettype none

module ofd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

### rtl/ofd_scan.sv
`default_nettype none

module ofd_scan
    import ofd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [CFG_W-1:0]             cfg_data,
    input  wire logic                         take,
    input  wire logic signed [CELL_W-1:0]     cell_value,
    input  wire logic                         pad,
    output logic                              ctx_valid,
    output ofd_ctx_t                          ctx,
    output logic [1:0]                        wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
    output logic [CELL_W-1:0]                 wr_data,
    output logic                              rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_a,
    output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_b
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (CFG_W > EW) ? CFG_W : EW;
    localparam int HCMP = (CFG_W > RW) ? CFG_W : RW;
    localparam int RDW  = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;

    logic [EW-1:0]  eff_width;
    logic [RW-1:0]  eff_height;
    logic           drain;
    logic           active;
    logic [CW-1:0]  col_eff;
    logic [EW-1:0]  col_plus;
    logic           col_last;
    logic [RDW-1:0] row_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_GRID_WIDTH)
            begin
                grid_width_reg <= cfg_data;
            end
            if (cfg_index == REG_GRID_HEIGHT)
            begin
                grid_height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            eff_width = EW'(1);
        end
        else if (WCMP'(grid_width_reg) > WCMP'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EW'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            eff_height = RW'(1);
        end
        else if (HCMP'(grid_height_reg) > HCMP'(MAX_HEIGHT))
        begin
            eff_height = RW'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = RW'(grid_height_reg);
        end
    end

    assign drain  = (row_reg >= eff_height);
    // drop early pad words without touching state
    assign active = take && !(pad && !drain);

    // wrap now if the width shrank under a running map
    assign col_eff  = (EW'(col_reg) >= eff_width) ? '0 : col_reg;
    assign col_plus = EW'(col_eff) + EW'(1);
    assign col_last = (col_plus >= eff_width);
    assign row_diff = RDW'(eff_height) - RDW'(row_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (active)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = drain ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = CW'(col_plus);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign wr_en[0] = active && !drain && !row_reg[0];
    assign wr_en[1] = active && !drain && row_reg[0];
    assign wr_addr  = col_eff;
    assign wr_data  = cell_value;

    assign rd_en     = active && (row_reg != '0);
    assign rd_addr_a = col_eff;
    assign rd_addr_b = CW'(col_plus);

    assign ctx_valid = rd_en;

    always_comb
    begin
        ctx.col        = COL_OUT_W'(col_eff);
        ctx.row        = ROW_OUT_W'(row_diff);
        ctx.last       = (row_reg == eff_height) && (col_plus == eff_width);
        ctx.below_free = !drain && (cell_value == CELL_FREE);
        ctx.own_par    = !row_reg[0];
        ctx.left_ok    = (col_eff != '0);
        ctx.right_ok   = !col_last;
        ctx.above_ok   = (row_reg >= RW'(2));
    end

endmodule

`default_nettype wire

### rtl/ofd_decide.sv
`default_nettype none

module ofd_decide
    import ofd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ofd_ctx_t             ctx,
    input  wire logic [CELL_W-1:0]    rd0_a,
    input  wire logic [CELL_W-1:0]    rd0_b,
    input  wire logic [CELL_W-1:0]    rd1_a,
    input  wire logic [CELL_W-1:0]    rd1_b,
    input  wire logic                 out_stall,
    output logic                      ready,
    output logic                      out_valid,
    output logic [COL_OUT_W-1:0]      cell_column,
    output logic [ROW_OUT_W-1:0]      cell_row,
    output logic                      is_frontier,
    output logic                      last_cell
);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    ofd_ctx_t       s1_ctx_reg;
    logic [CELL_W-1:0] left_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [COL_OUT_W-1:0] col_reg;
    logic [ROW_OUT_W-1:0] row_reg;
    logic           frontier_reg;
    logic           last_reg;

    logic           out_load;
    logic           advance;
    logic [CELL_W-1:0] center;
    logic [CELL_W-1:0] right;
    logic [CELL_W-1:0] above;
    logic           free_nb;
    logic           frontier;

    assign out_load = !out_valid_reg || !out_stall;
    assign ready    = !s1_valid_reg || out_load;
    assign advance  = s1_valid_reg && out_load;

    // own row sits in the bank of the previous raster row; the other bank holds two rows up
    assign center = s1_ctx_reg.own_par ? rd1_a : rd0_a;
    assign right  = s1_ctx_reg.own_par ? rd1_b : rd0_b;
    assign above  = s1_ctx_reg.own_par ? rd0_a : rd1_a;

    assign free_nb = s1_ctx_reg.below_free
                  || (s1_ctx_reg.above_ok && (above == CELL_FREE))
                  || (s1_ctx_reg.left_ok && (left_reg == CELL_FREE))
                  || (s1_ctx_reg.right_ok && (right == CELL_FREE));
    assign frontier = (center == CELL_UNKNOWN) && free_nb;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ready)
        begin
            s1_valid_next = load;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_ctx_reg <= ctx;
        end
        if (advance)
        begin
            // this center is the left neighbor of the next cell in the row
            left_reg     <= center;
            col_reg      <= s1_ctx_reg.col;
            row_reg      <= s1_ctx_reg.row;
            frontier_reg <= frontier;
            last_reg     <= s1_ctx_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_column = col_reg;
    assign cell_row    = row_reg;
    assign is_frontier = frontier_reg;
    assign last_cell   = last_reg;

endmodule

`default_nettype wire

### rtl/occupancy_frontier_detect_unit.sv
`default_nettype none

// Channel   Direction  Handshake            Word
// in        input      in_valid/in_stall    cell_value, pad
// out       output     out_valid/out_stall  cell_column, cell_row, is_frontier, last_cell
// cfg       input      cfg_write            cfg_index, cfg_data
//
// One word per clock in steady state while the output is not stalled. A word reads
// the line store at accept; its decision is formed from the registered store data in
// the decision stage and then lands in the output register.
// Reset clears counters and valids, sets width/height to 1024; the store is not cleared.
// A stalled output holds; one more word waits in the decision stage before in_stall rises.

module occupancy_frontier_detect_unit
    import ofd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [CELL_W-1:0] cell_value,
    input  wire logic                     pad,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [COL_OUT_W-1:0]          cell_column,
    output logic [ROW_OUT_W-1:0]          cell_row,
    output logic                          is_frontier,
    output logic                          last_cell,
    input  wire logic                     cfg_write,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic           ready;
    logic           take;
    logic           ctx_valid;
    ofd_ctx_t       ctx;
    logic [1:0]     wr_en;
    logic [AW-1:0]  wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr_a;
    logic [AW-1:0]  rd_addr_b;
    logic [CELL_W-1:0] rd0_a;
    logic [CELL_W-1:0] rd0_b;
    logic [CELL_W-1:0] rd1_a;
    logic [CELL_W-1:0] rd1_b;

    assign in_stall = !ready;
    assign take     = in_valid && ready;

    ofd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .cell_value (cell_value),
        .pad        (pad),
        .ctx_valid  (ctx_valid),
        .ctx        (ctx),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b)
    );

    // even raster rows
    ofd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .clk     (clk),
        .we      (wr_en[0]),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .re      (rd_en),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    // odd raster rows
    ofd_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .clk     (clk),
        .we      (wr_en[1]),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .re      (rd_en),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    ofd_decide u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ctx_valid),
        .ctx         (ctx),
        .rd0_a       (rd0_a),
        .rd0_b       (rd0_b),
        .rd1_a       (rd1_a),
        .rd1_b       (rd1_b),
        .out_stall   (out_stall),
        .ready       (ready),
        .out_valid   (out_valid),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .is_frontier (is_frontier),
        .last_cell   (last_cell)
    );

endmodule

`default_nettype wire
